// ----- rtl/core/abp_pkg.sv -----
// Shared types, constants and helpers for the box projector.
`default_nettype none

package abp_pkg;

  localparam int MAX_IMAGE_DIM   = 4096;
  localparam int PIXEL_FRAC_BITS = 4;
  localparam int NUM_CORNERS     = 8;

  localparam int DIM_W     = 13;
  localparam int COORD_W   = 32;
  localparam int DELTA_W   = COORD_W + 1;
  localparam int COEF_W    = 48;
  localparam int HALF_W    = COEF_W / 2;
  localparam int PROD_W    = DELTA_W + HALF_W + 1;
  localparam int CLIP_W    = 88;
  localparam int SCALE_W   = $clog2(MAX_IMAGE_DIM) + 1 + PIXEL_FRAC_BITS;
  localparam int PIX_W     = 16;
  localparam int NUM_AXES  = 3;
  localparam int NUM_LANES = 3;
  localparam int NUM_ROWS  = 4;
  localparam int AX_W      = $clog2(NUM_AXES);
  localparam int ROW_W     = $clog2(NUM_ROWS);
  localparam int CNT_W     = $clog2(NUM_CORNERS);
  localparam int MUL_STEPS = NUM_AXES * 4;
  localparam int STEP_W    = $clog2(MUL_STEPS + 1);
  localparam int QDEPTH    = 2;

  localparam logic [DIM_W-1:0] RESET_WIDTH  = 13'd1920;
  localparam logic [DIM_W-1:0] RESET_HEIGHT = 13'd1080;

  // configuration register indexes
  localparam logic [0:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [0:0] REG_IMAGE_HEIGHT = 1'b1;

  // matrix columns as coded in the coefficient index
  localparam logic [1:0] COL_X = 2'd0;
  localparam logic [1:0] COL_Y = 2'd1;
  localparam logic [1:0] COL_Z = 2'd2;
  localparam logic [1:0] COL_W = 2'd3;

  // stored columns; z is never needed
  localparam int LANE_X = 0;
  localparam int LANE_Y = 1;
  localparam int LANE_W = 2;

  localparam logic [ROW_W-1:0] ROW_TRANSLATE = 2'd3;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_BOX  = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t                                 kind;
    logic [3:0]                            coef_index;
    logic [COEF_W-1:0]                     coef_value;
    logic [NUM_AXES-1:0][COORD_W-1:0]      lo;
    logic [NUM_AXES-1:0][DELTA_W-1:0]      dlt;
  } req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic             done;
    logic             trunc;
    logic [PIX_W-1:0] pix;
  } pix_res_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > DIM_W'(MAX_IMAGE_DIM)) r = DIM_W'(MAX_IMAGE_DIM);
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/abp_front.sv -----
// Front end: classify an incoming item and prepare corner deltas.
`default_nettype none

module abp_front
  import abp_pkg::*;
(
  input  logic                      in_push,
  input  logic                      in_req_type,
  input  logic [3:0]                in_coef_index,
  input  logic signed [COEF_W-1:0]  in_coef_value,
  input  logic signed [COORD_W-1:0] in_box_lo_x,
  input  logic signed [COORD_W-1:0] in_box_lo_y,
  input  logic signed [COORD_W-1:0] in_box_lo_z,
  input  logic signed [COORD_W-1:0] in_box_hi_x,
  input  logic signed [COORD_W-1:0] in_box_hi_y,
  input  logic signed [COORD_W-1:0] in_box_hi_z,
  input  q_stat_t                   q_stat,
  output logic                      q_push,
  output req_t                      q_data
);

  logic [NUM_AXES-1:0][COORD_W-1:0] lo;
  logic [NUM_AXES-1:0][COORD_W-1:0] hi;

  assign lo = {in_box_lo_z, in_box_lo_y, in_box_lo_x};
  assign hi = {in_box_hi_z, in_box_hi_y, in_box_hi_x};

  assign q_push = in_push && !q_stat.full;

  always_comb begin
    q_data = '0;
    if (in_req_type == KIND_BOX) begin
      q_data.kind = KIND_BOX;
      for (int a = 0; a < NUM_AXES; a++) begin
        q_data.lo[a]  = lo[a];
        // span of the box on this axis, one bit wider than a coordinate
        q_data.dlt[a] = {hi[a][COORD_W-1], hi[a]} - {lo[a][COORD_W-1], lo[a]};
      end
    end else begin
      q_data.kind       = KIND_LOAD;
      q_data.coef_index = in_coef_index;
      q_data.coef_value = in_coef_value;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/abp_fifo.sv -----
// Short request queue between front and back end.
`default_nettype none

module abp_fifo
  import abp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  req_t    wdata,
  input  logic    pop,
  output req_t    head,
  output q_stat_t stat
);

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int QC_W  = $clog2(QDEPTH + 1);

  req_t             mem_r [QDEPTH];
  logic [PTR_W-1:0] wptr_r, rptr_r;
  logic [QC_W-1:0]  count_r;
  logic             do_push, do_pop;

  assign stat.full  = (count_r == QC_W'(QDEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (do_push) begin
        mem_r[wptr_r] <= wdata;
        wptr_r        <= wptr_r + 1'b1;
      end
      if (do_pop) rptr_r <= rptr_r + 1'b1;
      if (do_push && !do_pop) count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/abp_div.sv -----
// Radix-2 long division that maps one clip ratio to a clamped pixel coordinate.
`default_nettype none

module abp_div
  import abp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [CLIP_W-1:0] n,
  input  logic signed [CLIP_W-1:0] d,
  input  logic [DIM_W-1:0]         dim,
  output pix_res_t                 res
);

  localparam int REM_W = CLIP_W + 2;
  localparam int BIT_W = $clog2(SCALE_W);

  logic               busy_r, done_r, neg_r, over_r;
  logic [BIT_W-1:0]   bit_r;
  logic [REM_W-1:0]   rem_r, rem_nxt, trial, den1, den2;
  logic [SCALE_W-1:0] quo_r, quo_nxt, scale_r;
  logic [CLIP_W-1:0]  num_r, den_r;
  logic [PIX_W-1:0]   lim_r;

  // one bit of the scale a step; remainder stays below the divisor
  always_comb begin
    trial = {rem_r[REM_W-2:0], 1'b0} + (scale_r[bit_r] ? {2'b00, num_r} : REM_W'(0));
    den1  = {2'b00, den_r};
    den2  = {1'b0, den_r, 1'b0};
    if (trial >= den2) begin
      rem_nxt = trial - den2;
      quo_nxt = {quo_r[SCALE_W-2:0], 1'b0} + SCALE_W'(2);
    end else if (trial >= den1) begin
      rem_nxt = trial - den1;
      quo_nxt = {quo_r[SCALE_W-2:0], 1'b0} + SCALE_W'(1);
    end else begin
      rem_nxt = trial;
      quo_nxt = {quo_r[SCALE_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (bit_r == '0);
      if (start) begin
        busy_r  <= 1'b1;
        bit_r   <= BIT_W'(SCALE_W - 1);
        rem_r   <= '0;
        quo_r   <= '0;
        num_r   <= n;
        den_r   <= d;
        scale_r <= SCALE_W'(dim) << PIXEL_FRAC_BITS;
        lim_r   <= PIX_W'((SCALE_W'(dim) - SCALE_W'(1)) << PIXEL_FRAC_BITS);
        neg_r   <= n[CLIP_W-1];
        over_r  <= !n[CLIP_W-1] && (n >= d);
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= quo_nxt;
        if (bit_r == '0) busy_r <= 1'b0;
        else bit_r <= bit_r - 1'b1;
      end
    end
  end

  always_comb begin
    res.done  = done_r;
    res.trunc = neg_r || over_r;
    if (neg_r) res.pix = '0;
    else if (over_r) res.pix = lim_r;
    else if (quo_r > SCALE_W'(lim_r)) res.pix = lim_r;
    else res.pix = quo_r[PIX_W-1:0];
  end

endmodule

`default_nettype wire

// ----- rtl/core/abp_back.sv -----
// Back end: matrix store, clip transform, per-corner projection and result register.
`default_nettype none

module abp_back
  import abp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  req_t             q_head,
  input  q_stat_t          q_stat,
  output logic             q_pop,
  input  logic [DIM_W-1:0] image_width,
  input  logic [DIM_W-1:0] image_height,
  input  logic             out_pop,
  output logic             out_empty,
  output logic             out_visible,
  output logic             out_truncated,
  output logic [PIX_W-1:0] out_screen_min_x,
  output logic [PIX_W-1:0] out_screen_min_y,
  output logic [PIX_W-1:0] out_screen_max_x,
  output logic [PIX_W-1:0] out_screen_max_y
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_CLIP = 6'b000100,
    S_DIV  = 6'b001000,
    S_ACC  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  req_t   req_r;

  logic [COEF_W-1:0]        mat_r [NUM_LANES][NUM_ROWS];
  logic [STEP_W-1:0]        step_r;
  logic [AX_W-1:0]          row;
  logic                     tag_v_r, tag_op_r, tag_half_r;
  logic [AX_W-1:0]          tag_row_r;
  logic signed [PROD_W-1:0] prod_r [NUM_LANES];
  logic signed [PROD_W-1:0] prod_nxt [NUM_LANES];
  logic signed [CLIP_W-1:0] contrib [NUM_LANES];
  logic signed [CLIP_W-1:0] acc_r [NUM_LANES];
  logic signed [CLIP_W-1:0] dac_r [NUM_AXES][NUM_LANES];
  logic signed [DELTA_W-1:0] xop;
  logic signed [HALF_W:0]    part [NUM_LANES];

  logic [CNT_W-1:0]         cnt_r, cnt_inc;
  logic [NUM_AXES-1:0]      gray_r;
  logic [AX_W-1:0]          flip_b;
  logic signed [CLIP_W-1:0] nx_r, ny_r, dd_r;
  logic                     vis_r, div_go_r;
  pix_res_t                 res_x, res_y;
  logic [DIM_W-1:0]         wdim, hdim;

  logic [PIX_W-1:0] minx_r, miny_r, maxx_r, maxy_r;
  logic             any_r, trunc_r;
  logic             ovalid_r, ovalid_nxt, take_out;

  logic             ld_en;
  logic [1:0]       ld_lane;

  assign wdim = clamp_dim(image_width);
  assign hdim = clamp_dim(image_height);

  assign q_pop    = (state_r == S_IDLE) && !q_stat.empty;
  assign take_out = (state_r == S_OUT) && (!ovalid_r || out_pop);

  // column of a coefficient load; z is dropped
  always_comb begin
    ld_en   = 1'b1;
    ld_lane = 2'(LANE_X);
    case (q_head.coef_index[1:0])
      COL_X:   ld_lane = 2'(LANE_X);
      COL_Y:   ld_lane = 2'(LANE_Y);
      COL_W:   ld_lane = 2'(LANE_W);
      COL_Z:   ld_en   = 1'b0;
      default: ld_en   = 1'b0;
    endcase
  end

  // step = {axis, operand, half}: lo or span times low or high coefficient half
  assign row = AX_W'(step_r >> 2);

  always_comb begin
    xop = step_r[1] ? $signed(req_r.dlt[row])
                    : $signed({req_r.lo[row][COORD_W-1], req_r.lo[row]});
    for (int l = 0; l < NUM_LANES; l++) begin
      part[l] = step_r[0]
              ? $signed({mat_r[l][row][COEF_W-1], mat_r[l][row][COEF_W-1:HALF_W]})
              : $signed({1'b0, mat_r[l][row][HALF_W-1:0]});
      prod_nxt[l] = xop * part[l];
      contrib[l]  = $signed({{(CLIP_W-PROD_W){prod_r[l][PROD_W-1]}}, prod_r[l]});
      if (tag_half_r) contrib[l] = contrib[l] <<< HALF_W;
    end
  end

  // corners walk in Gray order: one span added or removed per corner
  always_comb begin
    cnt_inc = cnt_r + 1'b1;
    if (cnt_inc[0]) flip_b = AX_W'(0);
    else if (cnt_inc[1]) flip_b = AX_W'(1);
    else flip_b = AX_W'(2);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (!q_stat.empty && q_head.kind == KIND_BOX) state_nxt = S_MUL;
      S_MUL:  if (step_r == STEP_W'(MUL_STEPS)) state_nxt = S_CLIP;
      S_CLIP: state_nxt = S_DIV;
      S_DIV:  if (res_x.done) state_nxt = S_ACC;
      S_ACC:  state_nxt = (cnt_r == CNT_W'(NUM_CORNERS - 1)) ? S_OUT : S_CLIP;
      S_OUT:  if (!ovalid_r || out_pop) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ovalid_nxt = ovalid_r && !out_pop;
    if (take_out) ovalid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      tag_v_r  <= 1'b0;
      div_go_r <= 1'b0;
      ovalid_r <= 1'b0;
      for (int l = 0; l < NUM_LANES; l++)
        for (int r = 0; r < NUM_ROWS; r++)
          mat_r[l][r] <= '0;
    end else begin
      state_r    <= state_nxt;
      ovalid_r   <= ovalid_nxt;
      div_go_r   <= (state_r == S_CLIP);
      tag_v_r    <= (state_r == S_MUL) && (step_r < STEP_W'(MUL_STEPS));
      tag_row_r  <= row;
      tag_op_r   <= step_r[1];
      tag_half_r <= step_r[0];
      prod_r     <= prod_nxt;
      case (state_r)
        S_IDLE: begin
          if (!q_stat.empty) begin
            req_r <= q_head;
            if (q_head.kind == KIND_LOAD && ld_en)
              mat_r[ld_lane][q_head.coef_index[3:2]] <= q_head.coef_value;
            step_r  <= '0;
            cnt_r   <= '0;
            gray_r  <= '0;
            minx_r  <= '1;
            miny_r  <= '1;
            maxx_r  <= '0;
            maxy_r  <= '0;
            any_r   <= 1'b0;
            trunc_r <= 1'b0;
            for (int l = 0; l < NUM_LANES; l++) begin
              acc_r[l] <= $signed({{(CLIP_W-COEF_W){mat_r[l][ROW_TRANSLATE][COEF_W-1]}},
                                   mat_r[l][ROW_TRANSLATE]});
              for (int a = 0; a < NUM_AXES; a++) dac_r[a][l] <= '0;
            end
          end
        end
        S_MUL: begin
          step_r <= step_r + 1'b1;
          if (tag_v_r) begin
            for (int l = 0; l < NUM_LANES; l++) begin
              if (tag_op_r) dac_r[tag_row_r][l] <= dac_r[tag_row_r][l] + contrib[l];
              else acc_r[l] <= acc_r[l] + contrib[l];
            end
          end
        end
        S_CLIP: begin
          nx_r  <= acc_r[LANE_X] + acc_r[LANE_W];
          ny_r  <= acc_r[LANE_W] - acc_r[LANE_Y];
          dd_r  <= acc_r[LANE_W] <<< 1;
          vis_r <= !acc_r[LANE_W][CLIP_W-1] && (acc_r[LANE_W] != '0);
        end
        S_ACC: begin
          if (vis_r) begin
            any_r   <= 1'b1;
            trunc_r <= trunc_r || res_x.trunc || res_y.trunc;
            if (res_x.pix < minx_r) minx_r <= res_x.pix;
            if (res_x.pix > maxx_r) maxx_r <= res_x.pix;
            if (res_y.pix < miny_r) miny_r <= res_y.pix;
            if (res_y.pix > maxy_r) maxy_r <= res_y.pix;
          end
          if (cnt_r != CNT_W'(NUM_CORNERS - 1)) begin
            cnt_r          <= cnt_inc;
            gray_r[flip_b] <= !gray_r[flip_b];
            for (int l = 0; l < NUM_LANES; l++)
              acc_r[l] <= gray_r[flip_b] ? acc_r[l] - dac_r[flip_b][l]
                                         : acc_r[l] + dac_r[flip_b][l];
          end
        end
        default: ;
      endcase
      if (take_out) begin
        out_visible      <= any_r;
        out_truncated    <= any_r && trunc_r;
        out_screen_min_x <= any_r ? minx_r : '0;
        out_screen_min_y <= any_r ? miny_r : '0;
        out_screen_max_x <= any_r ? maxx_r : '0;
        out_screen_max_y <= any_r ? maxy_r : '0;
      end
    end
  end

  assign out_empty = !ovalid_r;

  abp_div u_div_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_go_r),
    .n     (nx_r),
    .d     (dd_r),
    .dim   (wdim),
    .res   (res_x)
  );

  abp_div u_div_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_go_r),
    .n     (ny_r),
    .d     (dd_r),
    .dim   (hdim),
    .res   (res_y)
  );

endmodule

`default_nettype wire

// ----- rtl/core/aabb_screen_bbox_projector.sv -----
// Top level of the screen-space bounding box projector.
//
//  channel  direction  handshake          beat
//  in_      input      push / full        coefficient load or world box
//  out_     output     pop / empty        visible, truncated, box edges
//  cfg_     input      cfg_we             image_width, image_height
//
// A box in the back end is dequeued, passes the multiplier, then for each corner
// goes through the clip step, the 17-step long division and the accumulate step.
// A load is stored as it is dequeued. Two items queue ahead of the back end.
// Reset is synchronous: matrix cleared, image size 1920 x 1080, queues empty.
// A stalled result holds in the output register while later items still enter.
`default_nettype none

module aabb_screen_bbox_projector
  import abp_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_push,
  output logic                      in_full,
  input  logic                      in_req_type,
  input  logic [3:0]                in_coef_index,
  input  logic signed [COEF_W-1:0]  in_coef_value,
  input  logic signed [COORD_W-1:0] in_box_lo_x,
  input  logic signed [COORD_W-1:0] in_box_lo_y,
  input  logic signed [COORD_W-1:0] in_box_lo_z,
  input  logic signed [COORD_W-1:0] in_box_hi_x,
  input  logic signed [COORD_W-1:0] in_box_hi_y,
  input  logic signed [COORD_W-1:0] in_box_hi_z,
  output logic                      out_empty,
  input  logic                      out_pop,
  output logic                      out_visible,
  output logic                      out_truncated,
  output logic [PIX_W-1:0]          out_screen_min_x,
  output logic [PIX_W-1:0]          out_screen_min_y,
  output logic [PIX_W-1:0]          out_screen_max_x,
  output logic [PIX_W-1:0]          out_screen_max_y,
  input  logic                      cfg_we,
  input  logic [0:0]                cfg_index,
  input  logic [DIM_W-1:0]          cfg_wdata
);

  logic [DIM_W-1:0] width_r, height_r;
  logic             q_push, q_pop;
  req_t             q_data, q_head;
  q_stat_t          q_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RESET_WIDTH;
      height_r <= RESET_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  width_r  <= cfg_wdata;
        REG_IMAGE_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_full = q_stat.full;

  abp_front u_front (
    .in_push       (in_push),
    .in_req_type   (in_req_type),
    .in_coef_index (in_coef_index),
    .in_coef_value (in_coef_value),
    .in_box_lo_x   (in_box_lo_x),
    .in_box_lo_y   (in_box_lo_y),
    .in_box_lo_z   (in_box_lo_z),
    .in_box_hi_x   (in_box_hi_x),
    .in_box_hi_y   (in_box_hi_y),
    .in_box_hi_z   (in_box_hi_z),
    .q_stat        (q_stat),
    .q_push        (q_push),
    .q_data        (q_data)
  );

  abp_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_data),
    .pop   (q_pop),
    .head  (q_head),
    .stat  (q_stat)
  );

  abp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_head           (q_head),
    .q_stat           (q_stat),
    .q_pop            (q_pop),
    .image_width      (width_r),
    .image_height     (height_r),
    .out_pop          (out_pop),
    .out_empty        (out_empty),
    .out_visible      (out_visible),
    .out_truncated    (out_truncated),
    .out_screen_min_x (out_screen_min_x),
    .out_screen_min_y (out_screen_min_y),
    .out_screen_max_x (out_screen_max_x),
    .out_screen_max_y (out_screen_max_y)
  );

endmodule

`default_nettype wire

// ----- rtl/core/abp_checker.sv -----
// Port-level checks for the box projector, bound to the top level.
`default_nettype none

module abp_checker
  import abp_pkg::*;
(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_push,
  input logic                      in_full,
  input logic                      out_empty,
  input logic                      out_pop,
  input logic                      out_visible,
  input logic                      out_truncated,
  input logic [PIX_W-1:0]          out_screen_min_x,
  input logic [PIX_W-1:0]          out_screen_min_y,
  input logic [PIX_W-1:0]          out_screen_max_x,
  input logic [PIX_W-1:0]          out_screen_max_y
);

  // queues come out of reset empty
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_visible) &&
      $stable(out_screen_min_x) && $stable(out_screen_max_y))
    else $error("result changed while stalled");

  // a box with no corner in front of the camera reports all zeros
  a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_visible |-> !out_truncated && out_screen_min_x == '0 &&
      out_screen_min_y == '0 && out_screen_max_x == '0 && out_screen_max_y == '0)
    else $error("hidden box with nonzero fields");

  // edges are ordered
  a_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_visible |-> out_screen_min_x <= out_screen_max_x &&
      out_screen_min_y <= out_screen_max_y)
    else $error("box edges out of order");

endmodule

bind aabb_screen_bbox_projector abp_checker u_abp_checker (.*);

`default_nettype wire

// ----- dv/tb_aabb_screen_bbox_projector.sv -----
// Testbench for the box projector: directed table, then random loads and boxes.
`timescale 1ns / 100ps
`default_nettype none

module tb_aabb_screen_bbox_projector;
  import abp_pkg::*;

  typedef struct {
    kind_t             kind;
    logic [3:0]        idx;
    logic [COEF_W-1:0] coef;
    logic [31:0]       lo [3];
    logic [31:0]       hi [3];
  } beat_t;

  typedef struct packed {
    logic        vis;
    logic        trunc;
    logic [15:0] min_x;
    logic [15:0] min_y;
    logic [15:0] max_x;
    logic [15:0] max_y;
  } bbox_t;

  typedef struct {
    beat_t b;
    logic  known;
    bbox_t res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0, in_full;
  logic in_req_type = 1'b0;
  logic [3:0] in_coef_index = '0;
  logic signed [COEF_W-1:0] in_coef_value = '0;
  logic signed [31:0] in_box_lo_x = '0, in_box_lo_y = '0, in_box_lo_z = '0;
  logic signed [31:0] in_box_hi_x = '0, in_box_hi_y = '0, in_box_hi_z = '0;
  logic out_empty, out_pop = 1'b0, out_visible, out_truncated;
  logic [PIX_W-1:0] out_screen_min_x, out_screen_min_y, out_screen_max_x, out_screen_max_y;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = REG_IMAGE_WIDTH;
  logic [DIM_W-1:0] cfg_wdata = '0;

  aabb_screen_bbox_projector i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic signed [COEF_W-1:0] matrix [16];
  logic [DIM_W-1:0] width_reg, height_reg;
  bbox_t boxes_due [$];
  int errors = 0;
  int send_idle = 20, recv_idle = 76;
  logic draining = 1'b0;

  // floor(dim*16*n/d) clamped; flags out-of-image corners
  function automatic logic [15:0] pixel_of(logic signed [127:0] n, logic signed [127:0] d,
                                           logic [DIM_W-1:0] dim, inout logic trunc);
    logic [15:0] lim;
    logic signed [127:0] q;
    lim = 16'((dim - 1) << PIXEL_FRAC_BITS);
    if (n < 0) begin
      trunc = 1'b1;
      return 16'd0;
    end
    if (n >= d) begin
      trunc = 1'b1;
      return lim;
    end
    q = (n * $signed({111'd0, dim, 4'd0})) / d;
    return (q > lim) ? lim : 16'(q);
  endfunction

  function automatic bbox_t project_box(beat_t b);
    bbox_t r;
    logic [DIM_W-1:0] wd, hd;
    logic signed [127:0] clip [4];
    logic signed [127:0] c;
    logic [15:0] px, py;
    logic any, tr;
    wd = clamp_dim(width_reg);
    hd = clamp_dim(height_reg);
    r = '{vis: 1'b0, trunc: 1'b0, min_x: 16'hFFFF, min_y: 16'hFFFF, max_x: 16'd0,
          max_y: 16'd0};
    any = 1'b0;
    tr = 1'b0;
    for (int k = 0; k < NUM_CORNERS; k++) begin
      for (int j = 0; j < 4; j++) begin
        clip[j] = 128'(matrix[12 + j]);
        for (int i = 0; i < 3; i++) begin
          c = ((k >> i) & 1) ? 128'($signed(b.hi[i])) : 128'($signed(b.lo[i]));
          clip[j] += c * 128'(matrix[i * 4 + j]);
        end
      end
      if (clip[3] > 0) begin
        px = pixel_of(clip[0] + clip[3], 2 * clip[3], wd, tr);
        py = pixel_of(clip[3] - clip[1], 2 * clip[3], hd, tr);
        if (px < r.min_x) r.min_x = px;
        if (px > r.max_x) r.max_x = px;
        if (py < r.min_y) r.min_y = py;
        if (py > r.max_y) r.max_y = py;
        any = 1'b1;
      end
    end
    if (!any) return '0;
    r.vis = 1'b1;
    r.trunc = tr;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  task automatic write_reg(logic [0:0] idx, logic [DIM_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) width_reg = val;
    else height_reg = val;
  endtask

  // push one beat; predictor runs when it is accepted
  task automatic send(beat_t b, logic known, bbox_t res);
    @(negedge clk);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push <= 1'b1;
    in_req_type <= b.kind;
    in_coef_index <= b.idx;
    in_coef_value <= b.coef;
    in_box_lo_x <= b.lo[0];
    in_box_lo_y <= b.lo[1];
    in_box_lo_z <= b.lo[2];
    in_box_hi_x <= b.hi[0];
    in_box_hi_y <= b.hi[1];
    in_box_hi_z <= b.hi[2];
    @(posedge clk);
    while (in_full) @(posedge clk);
    if (b.kind == KIND_LOAD) matrix[b.idx] = b.coef;
    else boxes_due.push_back(known ? res : project_box(b));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_push <= 1'b0;
    while (boxes_due.size() != 0) @(negedge clk);
    repeat (250) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom();
      1: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
      default: return 32'($signed($urandom_range(4000)) - 2000);
    endcase
  endfunction

  function automatic beat_t rand_box();
    beat_t b;
    b.kind = KIND_BOX;
    b.idx = 4'($urandom());
    b.coef = COEF_W'({$urandom(), $urandom()});
    for (int i = 0; i < 3; i++) begin
      b.lo[i] = rand_coord();
      b.hi[i] = rand_coord();
    end
    return b;
  endfunction

  function automatic beat_t rand_load(logic [3:0] idx);
    beat_t b;
    b = rand_box();
    b.kind = KIND_LOAD;
    b.idx = idx;
    case ($urandom_range(7))
      0: b.coef = COEF_W'({$urandom(), $urandom()});
      1: b.coef = $urandom_range(1) ? 48'h7FFFFFFFFFFF : 48'h800000000000;
      default: b.coef = COEF_W'($signed($urandom_range(262144)) - 131072);
    endcase
    return b;
  endfunction

  // simple perspective-like matrix with random content; w usually driven by z
  task automatic load_matrix();
    for (int i = 0; i < 16; i++) begin
      beat_t b;
      b = rand_load(4'(i));
      if (i == 11 && $urandom_range(3) != 0) b.coef = 48'h10000;
      send(b, 1'b0, '0);
    end
  endtask

  // result side
  initial begin
    bbox_t want;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      out_pop <= draining || recv_idle == 0 || $urandom_range(99) >= recv_idle;
      @(posedge clk);
      if (out_pop && !out_empty) begin
        if (boxes_due.size() == 0) begin
          $display("unexpected result at %0t", $time);
          errors++;
        end else begin
          want = boxes_due.pop_front();
          if (out_visible !== want.vis)
            report_mismatch("visible", 16'(out_visible), 16'(want.vis));
          if (out_truncated !== want.trunc)
            report_mismatch("truncated", 16'(out_truncated), 16'(want.trunc));
          if (out_screen_min_x !== want.min_x)
            report_mismatch("min_x", out_screen_min_x, want.min_x);
          if (out_screen_min_y !== want.min_y)
            report_mismatch("min_y", out_screen_min_y, want.min_y);
          if (out_screen_max_x !== want.max_x)
            report_mismatch("max_x", out_screen_max_x, want.max_x);
          if (out_screen_max_y !== want.max_y)
            report_mismatch("max_y", out_screen_max_y, want.max_y);
        end
      end
    end
  end

  initial begin
    row_t plan [$];
    beat_t b;
    for (int i = 0; i < 16; i++) matrix[i] = '0;
    width_reg = RESET_WIDTH;
    height_reg = RESET_HEIGHT;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // directed: zero matrix -> w = 0 everywhere, nothing visible
    b = rand_box();
    for (int i = 0; i < 3; i++) begin
      b.lo[i] = 32'h80000000;
      b.hi[i] = 32'h7FFFFFFF;
    end
    plan.push_back('{b: b, known: 1'b1, res: '0});
    // identity-like: x->x, y->y, w = 1 from translate
    b.kind = KIND_LOAD;
    b.idx = 4'd0;  b.coef = 48'h10000; plan.push_back('{b: b, known: 1'b0, res: '0});
    b.idx = 4'd5;  plan.push_back('{b: b, known: 1'b0, res: '0});
    b.idx = 4'd15; plan.push_back('{b: b, known: 1'b0, res: '0});
    b.kind = KIND_BOX;
    // point at origin: center pixel
    for (int i = 0; i < 3; i++) begin
      b.lo[i] = 0;
      b.hi[i] = 0;
    end
    plan.push_back('{b: b, known: 1'b1,
                     res: '{1'b1, 1'b0, 16'd15360, 16'd8640, 16'd15360, 16'd8640}});
    // huge box: truncated, clamped to full image
    for (int i = 0; i < 3; i++) begin
      b.lo[i] = 32'h80000000;
      b.hi[i] = 32'h7FFFFFFF;
    end
    plan.push_back('{b: b, known: 1'b1,
                     res: '{1'b1, 1'b1, 16'd0, 16'd0, 16'd30704, 16'd17264}});
    // inverted box, edge corners
    b.lo[0] = 1; b.hi[0] = -1; b.lo[1] = -1; b.hi[1] = 1;
    plan.push_back('{b: b, known: 1'b0, res: '0});
    // negative w: behind camera
    b.kind = KIND_LOAD; b.idx = 4'd15; b.coef = 48'h800000000000;
    plan.push_back('{b: b, known: 1'b0, res: '0});
    b.kind = KIND_BOX;
    plan.push_back('{b: b, known: 1'b1, res: '0});
    // w from z only: partial visibility
    b.kind = KIND_LOAD; b.idx = 4'd15; b.coef = 48'd0;
    plan.push_back('{b: b, known: 1'b0, res: '0});
    b.idx = 4'd11; b.coef = 48'h7FFFFFFFFFFF;
    plan.push_back('{b: b, known: 1'b0, res: '0});
    b.kind = KIND_BOX; b.lo[2] = -5; b.hi[2] = 7;
    plan.push_back('{b: b, known: 1'b0, res: '0});
    foreach (plan[i]) send(plan[i].b, plan[i].known, plan[i].res);

    // phases of idling and image sizes
    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      case (ph)
        0: begin write_reg(REG_IMAGE_WIDTH, 13'd0); write_reg(REG_IMAGE_HEIGHT, 13'd8191); end
        1: begin write_reg(REG_IMAGE_WIDTH, 13'd4096); write_reg(REG_IMAGE_HEIGHT, 13'd1); end
        2: begin
          write_reg(REG_IMAGE_WIDTH, 13'($urandom_range(1, 4096)));
          write_reg(REG_IMAGE_HEIGHT, 13'($urandom_range(1, 4096)));
        end
        3: begin
          send_idle = 76; recv_idle = 20;
          write_reg(REG_IMAGE_WIDTH, 13'd4097); write_reg(REG_IMAGE_HEIGHT, 13'd4096);
        end
        4: begin send_idle = 0; recv_idle = 0;
          write_reg(REG_IMAGE_WIDTH, 13'd640); write_reg(REG_IMAGE_HEIGHT, 13'd480); end
        default: begin
          write_reg(REG_IMAGE_WIDTH, 13'($urandom()));
          write_reg(REG_IMAGE_HEIGHT, 13'($urandom()));
        end
      endcase
      load_matrix();
      for (int n = 0; n < 123; n++) begin
        if ($urandom_range(9) == 0) send(rand_load(4'($urandom())), 1'b0, '0);
        else send(rand_box(), 1'b0, '0);
      end
    end

    draining = 1'b1;
    wait_idle();
    if (errors == 0 && boxes_due.size() == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/core/abp_pkg.sv
rtl/core/abp_front.sv
rtl/core/abp_fifo.sv
rtl/core/abp_div.sv
rtl/core/abp_back.sv
rtl/core/aabb_screen_bbox_projector.sv
rtl/core/abp_checker.sv
dv/tb_aabb_screen_bbox_projector.sv
